[design/pptec_pkg.sv]
// Package for the pre/post trigger event capture block.
// Holds field widths, command/kind/register codes, state encoding and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pptec_pkg;

  localparam int TAG_W   = 32;
  localparam int TIME_W  = 40;
  localparam int ROLL_W  = 20;
  localparam int CMD_W   = 2;
  localparam int LEVEL_W = 2;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ROLL_W;

  // Extra slack added to the pre-roll when trimming the ring by age.
  localparam logic [TIME_W-1:0] SPAN_SLACK_MS = TIME_W'(2000);
  localparam logic [TIME_W-1:0] TIME_MAX      = '1;

  localparam logic [CMD_W-1:0] CMD_PACKET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALARM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LVL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_ROLL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_ROLL = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL_LD,
    ST_SPAN,
    ST_DROP_LD,
    ST_WALK_RD,
    ST_WALK_CHK
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] time_ms;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  out_tag;
    logic [TIME_W-1:0] out_time_ms;
    logic              closes_session;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

[design/pptec_if.sv]
// Channel interfaces for the capture block: input command words and result words.
// Depends on pptec_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pptec_in_if;
  logic                          valid;
  logic                          ready;
  logic [pptec_pkg::CMD_W-1:0]   cmd;
  logic [pptec_pkg::TAG_W-1:0]   packet_tag;
  logic [pptec_pkg::TIME_W-1:0]  time_ms;
  logic [pptec_pkg::LEVEL_W-1:0] alarm_level;

  modport source (output valid, output cmd, output packet_tag, output time_ms,
                  output alarm_level, input ready);
  modport sink   (input valid, input cmd, input packet_tag, input time_ms,
                  input alarm_level, output ready);
endinterface

interface pptec_out_if;
  logic                         valid;
  logic                         ready;
  logic [pptec_pkg::KIND_W-1:0] kind;
  logic [pptec_pkg::TAG_W-1:0]  out_tag;
  logic [pptec_pkg::TIME_W-1:0] out_time_ms;
  logic                         closes_session;
  logic                         last;

  modport source (output valid, output kind, output out_tag, output out_time_ms,
                  output closes_session, output last, input ready);
  modport sink   (input valid, input kind, input out_tag, input out_time_ms,
                  input closes_session, input last, output ready);
endinterface

`default_nettype wire

[design/pptec_ring_mem.sv]
// Ring storage for packet tags and timestamps: one write port, one read port,
// read data registered on the read enable and valid in the cycle after it. Depends on pptec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pptec_ring_mem #(
  parameter int DEPTH = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire pptec_pkg::entry_t wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output pptec_pkg::entry_t      rdata
);

  pptec_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/pre_post_trigger_event_capture.sv]
// Pre/post trigger event capture. Packets are kept in a ring memory of RING_DEPTH
// entries and trimmed by count and by age. When the ring is full, a packet first
// drops the oldest entry; each trim needs a read of the new oldest entry from the
// single read port. An alarm that opens a session replays the buffered entries,
// walking the ring one read at a time, and the final result then leaves through
// the hold stage. A stalled result channel holds off new words, as a new word is
// taken only once the pending result has left the hold stage.
// Depends on pptec_pkg, pptec_if and pptec_ring_mem.
`timescale 1ns / 1ps
`default_nettype none

module pre_post_trigger_event_capture #(
  parameter int RING_DEPTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  pptec_in_if.sink                               in_ch,
  pptec_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [pptec_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [pptec_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_I = (IDX_W + 1)'(RING_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
  localparam int TW = pptec_pkg::TIME_W;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_I) begin
      s = s - DEPTH_I;
    end
    return s[IDX_W-1:0];
  endfunction

  // Configuration registers.
  logic                              enabled_r;
  logic [pptec_pkg::LEVEL_W-1:0]     trig_level_r;
  logic [pptec_pkg::ROLL_W-1:0]      pre_roll_r;
  logic [pptec_pkg::ROLL_W-1:0]      post_roll_r;

  // Control state.
  pptec_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TW-1:0]    first_time_r, first_time_nxt;
  logic [TW-1:0]    newest_time_r, newest_time_nxt;
  logic             session_open_r, session_open_nxt;
  logic [TW-1:0]    stop_time_r, stop_time_nxt;
  logic [IDX_W-1:0] walk_k_r, walk_k_nxt;
  logic [TW-1:0]    win_lo_r, win_lo_nxt;
  logic [TW-1:0]    win_hi_r, win_hi_nxt;

  // Hold stage: the newest result, whose last flag is settled once hold_final_r is set.
  pptec_pkg::result_t hold_r, hold_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  logic               hold_final_r, hold_final_nxt;

  pptec_pkg::result_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Memory port.
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  pptec_pkg::entry_t  mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  pptec_pkg::entry_t  mem_rdata;

  logic               in_ready;
  logic               in_fire;
  logic               out_free;
  logic [TW:0]        stop_sum;
  logic [TW-1:0]      alarm_stop;
  logic [TW-1:0]      pre_ext;
  logic [TW-1:0]      alarm_lo;
  logic [TW-1:0]      span_lim;
  logic               span_over;
  logic               ring_full;
  logic [IDX_W-1:0]   head_inc;
  logic [IDX_W-1:0]   tail_slot;
  logic [IDX_W-1:0]   walk_addr;
  logic               rd_in_win;
  logic               walk_last;

  pptec_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready     = (state_r == pptec_pkg::ST_IDLE) && !hold_valid_r;
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.out_tag        = out_r.out_tag;
  assign out_ch.out_time_ms    = out_r.out_time_ms;
  assign out_ch.closes_session = out_r.closes_session;
  assign out_ch.last           = out_r.last;

  assign stop_sum   = {1'b0, in_ch.time_ms} + (TW + 1)'(post_roll_r);
  assign alarm_stop = stop_sum[TW] ? pptec_pkg::TIME_MAX : stop_sum[TW-1:0];
  assign pre_ext    = TW'(pre_roll_r);
  assign alarm_lo   = (in_ch.time_ms > pre_ext) ? (in_ch.time_ms - pre_ext) : '0;
  assign span_lim   = pre_ext + pptec_pkg::SPAN_SLACK_MS;
  assign span_over  = (count_r > CNT_W'(1)) && (newest_time_r > first_time_r) &&
                      ((newest_time_r - first_time_r) > span_lim);

  assign ring_full  = (count_r == DEPTH_C);
  assign head_inc   = wrap_add(head_r, IDX_W'(1));
  assign tail_slot  = wrap_add(head_r, count_r[IDX_W-1:0]);
  assign walk_addr  = wrap_add(head_r, walk_k_r);
  assign rd_in_win  = (mem_rdata.time_ms >= win_lo_r) && (mem_rdata.time_ms <= win_hi_r);
  assign walk_last  = ((CNT_W'(walk_k_r) + CNT_W'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      trig_level_r <= pptec_pkg::LEVEL_W'(1);
      pre_roll_r   <= pptec_pkg::ROLL_W'(5000);
      post_roll_r  <= pptec_pkg::ROLL_W'(5000);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pptec_pkg::CFG_ENABLED:   enabled_r    <= cfg_wdata[0];
        pptec_pkg::CFG_TRIG_LVL:  trig_level_r <= cfg_wdata[pptec_pkg::LEVEL_W-1:0];
        pptec_pkg::CFG_PRE_ROLL:  pre_roll_r   <= cfg_wdata;
        pptec_pkg::CFG_POST_ROLL: post_roll_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= pptec_pkg::ST_IDLE;
      head_r         <= '0;
      count_r        <= '0;
      first_time_r   <= '0;
      newest_time_r  <= '0;
      session_open_r <= 1'b0;
      stop_time_r    <= '0;
      walk_k_r       <= '0;
      hold_valid_r   <= 1'b0;
      hold_final_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      head_r         <= head_nxt;
      count_r        <= count_nxt;
      first_time_r   <= first_time_nxt;
      newest_time_r  <= newest_time_nxt;
      session_open_r <= session_open_nxt;
      stop_time_r    <= stop_time_nxt;
      walk_k_r       <= walk_k_nxt;
      hold_valid_r   <= hold_valid_nxt;
      hold_final_r   <= hold_final_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
    win_lo_r <= win_lo_nxt;
    win_hi_r <= win_hi_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    count_nxt        = count_r;
    first_time_nxt   = first_time_r;
    newest_time_nxt  = newest_time_r;
    session_open_nxt = session_open_r;
    stop_time_nxt    = stop_time_r;
    walk_k_nxt       = walk_k_r;
    win_lo_nxt       = win_lo_r;
    win_hi_nxt       = win_hi_r;
    hold_nxt         = hold_r;
    hold_valid_nxt   = hold_valid_r;
    hold_final_nxt   = hold_final_r;
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;

    mem_we            = 1'b0;
    mem_waddr         = tail_slot;
    mem_wdata.tag     = in_ch.packet_tag;
    mem_wdata.time_ms = in_ch.time_ms;
    mem_re            = 1'b0;
    mem_raddr         = head_inc;

    // A settled result in the hold stage moves on as soon as the output is free.
    if (hold_valid_r && hold_final_r && out_free) begin
      out_nxt        = hold_r;
      out_nxt.last   = 1'b1;
      out_valid_nxt  = 1'b1;
      hold_valid_nxt = 1'b0;
      hold_final_nxt = 1'b0;
    end

    unique case (state_r)
      pptec_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (in_ch.cmd == pptec_pkg::CMD_PACKET) begin
            if (enabled_r) begin
              mem_we          = 1'b1;
              newest_time_nxt = in_ch.time_ms;
              if (ring_full) begin
                // Drop the oldest first: the new word lands in its slot and the
                // following entry becomes the oldest.
                mem_waddr = head_r;
                mem_re    = 1'b1;
                mem_raddr = head_inc;
                head_nxt  = head_inc;
                state_nxt = pptec_pkg::ST_FULL_LD;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                if (count_r == '0) begin
                  first_time_nxt = in_ch.time_ms;
                end
                state_nxt = pptec_pkg::ST_SPAN;
              end
              if (session_open_r) begin
                hold_nxt.kind           = pptec_pkg::KIND_WRITE;
                hold_nxt.out_tag        = in_ch.packet_tag;
                hold_nxt.out_time_ms    = in_ch.time_ms;
                hold_nxt.closes_session = (in_ch.time_ms >= stop_time_r);
                hold_nxt.last           = 1'b1;
                hold_valid_nxt          = 1'b1;
                hold_final_nxt          = 1'b1;
                session_open_nxt        = (in_ch.time_ms < stop_time_r);
              end
            end
          end else if (in_ch.cmd == pptec_pkg::CMD_ALARM) begin
            if (enabled_r && (in_ch.alarm_level >= trig_level_r)) begin
              if (session_open_r) begin
                if (alarm_stop > stop_time_r) begin
                  stop_time_nxt = alarm_stop;
                end
              end else begin
                session_open_nxt        = 1'b1;
                stop_time_nxt           = alarm_stop;
                hold_nxt.kind           = pptec_pkg::KIND_OPEN;
                hold_nxt.out_tag        = '0;
                hold_nxt.out_time_ms    = in_ch.time_ms;
                hold_nxt.closes_session = 1'b0;
                hold_nxt.last           = 1'b0;
                hold_valid_nxt          = 1'b1;
                hold_final_nxt          = (count_r == '0);
                win_lo_nxt              = alarm_lo;
                win_hi_nxt              = in_ch.time_ms;
                walk_k_nxt              = '0;
                if (count_r != '0) begin
                  state_nxt = pptec_pkg::ST_WALK_RD;
                end
              end
            end
          end else if (in_ch.cmd == pptec_pkg::CMD_FLUSH) begin
            if (session_open_r) begin
              session_open_nxt        = 1'b0;
              hold_nxt.kind           = pptec_pkg::KIND_CLOSE;
              hold_nxt.out_tag        = '0;
              hold_nxt.out_time_ms    = '0;
              hold_nxt.closes_session = 1'b0;
              hold_nxt.last           = 1'b1;
              hold_valid_nxt          = 1'b1;
              hold_final_nxt          = 1'b1;
            end
          end else begin
            // Reserved command code: the word is consumed without effect.
          end
        end
      end

      pptec_pkg::ST_FULL_LD: begin
        first_time_nxt = mem_rdata.time_ms;
        state_nxt      = pptec_pkg::ST_SPAN;
      end

      pptec_pkg::ST_SPAN: begin
        if (span_over) begin
          // Count stays above zero after the drop, so the new oldest is always read.
          head_nxt  = head_inc;
          count_nxt = count_r - CNT_W'(1);
          mem_re    = 1'b1;
          mem_raddr = head_inc;
          state_nxt = pptec_pkg::ST_DROP_LD;
        end else begin
          state_nxt = pptec_pkg::ST_IDLE;
        end
      end

      pptec_pkg::ST_DROP_LD: begin
        first_time_nxt = mem_rdata.time_ms;
        state_nxt      = pptec_pkg::ST_SPAN;
      end

      pptec_pkg::ST_WALK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = walk_addr;
        state_nxt = pptec_pkg::ST_WALK_CHK;
      end

      pptec_pkg::ST_WALK_CHK: begin
        if (rd_in_win) begin
          // A new replayed word proves the held one is not the last.
          if (out_free) begin
            out_nxt                 = hold_r;
            out_nxt.last            = 1'b0;
            out_valid_nxt           = 1'b1;
            hold_nxt.kind           = pptec_pkg::KIND_WRITE;
            hold_nxt.out_tag        = mem_rdata.tag;
            hold_nxt.out_time_ms    = mem_rdata.time_ms;
            hold_nxt.closes_session = 1'b0;
            hold_nxt.last           = 1'b0;
            hold_final_nxt          = walk_last;
            walk_k_nxt              = walk_k_r + IDX_W'(1);
            state_nxt = walk_last ? pptec_pkg::ST_IDLE : pptec_pkg::ST_WALK_RD;
          end
        end else begin
          hold_final_nxt = walk_last;
          walk_k_nxt     = walk_k_r + IDX_W'(1);
          state_nxt      = walk_last ? pptec_pkg::ST_IDLE : pptec_pkg::ST_WALK_RD;
        end
      end

      default: begin
        state_nxt = pptec_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("ring count exceeds ring depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < DEPTH_I)
    else $error("ring head out of range");

  a_walk_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pptec_pkg::ST_WALK_RD || state_r == pptec_pkg::ST_WALK_CHK)
      |-> (hold_valid_r && !hold_final_r))
    else $error("replay walk without an unsettled held result");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pptec_pkg::ST_DROP_LD) |-> (count_r != '0))
    else $error("age trim left the ring empty");

  a_hold_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && hold_final_r && !out_valid_r) |=> !hold_valid_r)
    else $error("settled result did not move to a free output");

endmodule

`default_nettype wire

[sim/tb_pre_post_trigger_event_capture.sv]
// Testbench for pre_post_trigger_event_capture: directed and random command words,
// checked against an in-bench predictor of the capture ring and recording session.
// Depends on pptec_pkg, pptec_if and the capture block RTL.
`timescale 1ns / 1ps

module tb_pre_post_trigger_event_capture;

  localparam int RING_DEPTH    = 32;
  localparam int CLK_PERIOD    = 4;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 50;
  localparam logic [pptec_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // Predicts the capture block and holds the result words still to come.
  class capture_scoreboard;
    logic [pptec_pkg::TAG_W-1:0]  tags   [RING_DEPTH];
    logic [pptec_pkg::TIME_W-1:0] stamps [RING_DEPTH];
    int unsigned                  head;
    int unsigned                  count;
    logic [pptec_pkg::TIME_W-1:0] oldest_ms;
    logic [pptec_pkg::TIME_W-1:0] newest_ms;
    logic [pptec_pkg::TIME_W-1:0] stop_ms;
    bit                           recording;
    bit                           en;
    logic [1:0]                   trig;
    logic [pptec_pkg::ROLL_W-1:0] pre_ms;
    logic [pptec_pkg::ROLL_W-1:0] post_ms;
    pptec_pkg::result_t           expected_q[$];
    int unsigned                  mismatches;

    function new();
      head       = 0;
      count      = 0;
      oldest_ms  = '0;
      newest_ms  = '0;
      stop_ms    = '0;
      recording  = 1'b0;
      en         = 1'b0;
      trig       = 2'd1;
      pre_ms     = pptec_pkg::ROLL_W'(5000);
      post_ms    = pptec_pkg::ROLL_W'(5000);
      mismatches = 0;
    endfunction

    function void set_reg(logic [pptec_pkg::CFG_IDX_W-1:0] idx,
                          logic [pptec_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        pptec_pkg::CFG_ENABLED:   en = val[0];
        pptec_pkg::CFG_TRIG_LVL:  trig = val[1:0];
        pptec_pkg::CFG_PRE_ROLL:  pre_ms = val;
        pptec_pkg::CFG_POST_ROLL: post_ms = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void drop_oldest();
      if (count == 0) return;
      head  = (head + 1) % RING_DEPTH;
      count = count - 1;
      oldest_ms = (count > 0) ? stamps[head] : '0;
    endfunction

    function void add_result(logic [pptec_pkg::KIND_W-1:0] kind,
                             logic [pptec_pkg::TAG_W-1:0] tag,
                             logic [pptec_pkg::TIME_W-1:0] t, logic closes);
      pptec_pkg::result_t r;
      r.kind           = kind;
      r.out_tag        = tag;
      r.out_time_ms    = t;
      r.closes_session = closes;
      r.last           = 1'b0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_word(logic [pptec_pkg::CMD_W-1:0] cmd,
                            logic [pptec_pkg::TAG_W-1:0] tag,
                            logic [pptec_pkg::TIME_W-1:0] t,
                            logic [pptec_pkg::LEVEL_W-1:0] lvl);
      int unsigned                  first_new;
      int unsigned                  slot;
      int unsigned                  idx;
      int unsigned                  k;
      logic [pptec_pkg::TIME_W-1:0] span_ms;
      logic [pptec_pkg::TIME_W-1:0] stop_new;
      logic [pptec_pkg::TIME_W-1:0] window_lo;
      logic [pptec_pkg::TIME_W:0]   stop_sum;
      bit                           closing;
      pptec_pkg::result_t           tail;
      first_new = expected_q.size();
      span_ms   = pptec_pkg::TIME_W'(pre_ms) + pptec_pkg::SPAN_SLACK_MS;
      stop_sum  = {1'b0, t} + (pptec_pkg::TIME_W + 1)'(post_ms);
      stop_new  = stop_sum[pptec_pkg::TIME_W] ? pptec_pkg::TIME_MAX :
                  stop_sum[pptec_pkg::TIME_W-1:0];
      case (cmd)
        pptec_pkg::CMD_PACKET: begin
          if (en) begin
            if (count >= RING_DEPTH) drop_oldest();
            slot = (head + count) % RING_DEPTH;
            tags[slot]   = tag;
            stamps[slot] = t;
            count        = count + 1;
            newest_ms    = t;
            if (count == 1) oldest_ms = t;
            // Age trimming only applies while the newest packet is later than the oldest.
            while (count > 1 && newest_ms > oldest_ms && newest_ms - oldest_ms > span_ms)
              drop_oldest();
            if (recording) begin
              closing = (t >= stop_ms);
              add_result(pptec_pkg::KIND_WRITE, tag, t, closing);
              if (closing) recording = 1'b0;
            end
          end
        end
        pptec_pkg::CMD_ALARM: begin
          if (en && lvl >= trig) begin
            if (recording) begin
              if (stop_new > stop_ms) stop_ms = stop_new;
            end else begin
              recording = 1'b1;
              stop_ms   = stop_new;
              add_result(pptec_pkg::KIND_OPEN, '0, t, 1'b0);
              window_lo = (t > pptec_pkg::TIME_W'(pre_ms)) ?
                          t - pptec_pkg::TIME_W'(pre_ms) : '0;
              for (k = 0; k < count; k++) begin
                idx = (head + k) % RING_DEPTH;
                if (stamps[idx] >= window_lo && stamps[idx] <= t)
                  add_result(pptec_pkg::KIND_WRITE, tags[idx], stamps[idx], 1'b0);
              end
            end
          end
        end
        pptec_pkg::CMD_FLUSH: begin
          if (recording) begin
            recording = 1'b0;
            add_result(pptec_pkg::KIND_CLOSE, '0, '0, 1'b0);
          end
        end
        default: ;
      endcase
      if (expected_q.size() > first_new) begin
        tail = expected_q[expected_q.size() - 1];
        tail.last = 1'b1;
        expected_q[expected_q.size() - 1] = tail;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(pptec_pkg::result_t got);
      pptec_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: kind %0d tag %0h time %0h", got.kind, got.out_tag,
               got.out_time_ms);
        mismatches++;
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      compare_field("kind", 64'(want.kind), 64'(got.kind));
      compare_field("out_tag", 64'(want.out_tag), 64'(got.out_tag));
      compare_field("out_time_ms", 64'(want.out_time_ms), 64'(got.out_time_ms));
      compare_field("closes_session", 64'(want.closes_session), 64'(got.closes_session));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                             cfg_we;
  logic [pptec_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [pptec_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pptec_in_if  in_ch ();
  pptec_out_if out_ch ();

  capture_scoreboard  sb;
  pptec_pkg::result_t got_word;
  int                 idle_pct  = 22;
  int                 stall_pct = 22;
  int                 quiet_cycles = 0;

  pre_post_trigger_event_capture #(
    .RING_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side back-pressure.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // Results are checked before the word taken at the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_ch.valid && out_ch.ready) begin
        got_word.kind           = out_ch.kind;
        got_word.out_tag        = out_ch.out_tag;
        got_word.out_time_ms    = out_ch.out_time_ms;
        got_word.closes_session = out_ch.closes_session;
        got_word.last           = out_ch.last;
        sb.check_result(got_word);
      end
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.cmd, in_ch.packet_tag, in_ch.time_ms, in_ch.alarm_level);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(input logic [pptec_pkg::CMD_W-1:0] cmd,
                           input logic [pptec_pkg::TAG_W-1:0] tag,
                           input logic [pptec_pkg::TIME_W-1:0] t,
                           input logic [pptec_pkg::LEVEL_W-1:0] lvl);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.packet_tag  <= tag;
    in_ch.time_ms     <= t;
    in_ch.alarm_level <= lvl;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // The extra edge lets the monitor predict the word accepted last.
  task automatic hold_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input logic en, input logic [1:0] trig,
                                input logic [pptec_pkg::ROLL_W-1:0] pre,
                                input logic [pptec_pkg::ROLL_W-1:0] post);
    hold_for_drain();
    // A packet that gives no result may still be trimming the ring.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= pptec_pkg::CFG_ENABLED;
    cfg_wdata <= pptec_pkg::CFG_DATA_W'(en);
    @(posedge clk);
    sb.set_reg(pptec_pkg::CFG_ENABLED, pptec_pkg::CFG_DATA_W'(en));
    cfg_idx   <= pptec_pkg::CFG_TRIG_LVL;
    cfg_wdata <= pptec_pkg::CFG_DATA_W'(trig);
    @(posedge clk);
    sb.set_reg(pptec_pkg::CFG_TRIG_LVL, pptec_pkg::CFG_DATA_W'(trig));
    cfg_idx   <= pptec_pkg::CFG_PRE_ROLL;
    cfg_wdata <= pre;
    @(posedge clk);
    sb.set_reg(pptec_pkg::CFG_PRE_ROLL, pre);
    cfg_idx   <= pptec_pkg::CFG_POST_ROLL;
    cfg_wdata <= post;
    @(posedge clk);
    sb.set_reg(pptec_pkg::CFG_POST_ROLL, post);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n_items, input logic [pptec_pkg::TIME_W-1:0] base_ms);
    logic [pptec_pkg::TIME_W-1:0] now_ms;
    int unsigned                  max_step;
    int unsigned                  roll;
    int                           done_items;
    bit                           paused;
    now_ms     = base_ms;
    done_items = 0;
    paused     = 1'b0;
    max_step   = (int'(sb.pre_ms) + 2000) / 24 + 1;
    while (done_items < n_items) begin
      roll = $urandom_range(99);
      if (!paused && done_items >= n_items / 2) begin
        paused = 1'b1;
        hold_for_drain();
      end
      if (roll < 62) begin
        now_ms = now_ms + pptec_pkg::TIME_W'($urandom_range(max_step));
        send_word(pptec_pkg::CMD_PACKET, pptec_pkg::TAG_W'($urandom), now_ms,
                  pptec_pkg::LEVEL_W'($urandom));
      end else if (roll < 75) begin
        send_word(pptec_pkg::CMD_ALARM, pptec_pkg::TAG_W'($urandom),
                  now_ms + pptec_pkg::TIME_W'($urandom_range(max_step)),
                  pptec_pkg::LEVEL_W'($urandom_range(3, sb.trig)));
      end else if (roll < 80) begin
        send_word(pptec_pkg::CMD_ALARM, pptec_pkg::TAG_W'($urandom), now_ms,
                  pptec_pkg::LEVEL_W'($urandom));
      end else if (roll < 86) begin
        send_word(pptec_pkg::CMD_FLUSH, pptec_pkg::TAG_W'($urandom),
                  pptec_pkg::TIME_W'({$urandom, $urandom}), pptec_pkg::LEVEL_W'($urandom));
      end else if (roll < 91) begin
        // A long gap ages out many buffered packets at once.
        now_ms = now_ms + pptec_pkg::TIME_W'($urandom_range(3 * (int'(sb.pre_ms) + 2000)));
        send_word(pptec_pkg::CMD_PACKET, pptec_pkg::TAG_W'($urandom), now_ms,
                  pptec_pkg::LEVEL_W'($urandom));
      end else if (roll < 95) begin
        send_word(pptec_pkg::CMD_PACKET, pptec_pkg::TAG_W'($urandom),
                  pptec_pkg::TIME_W'({$urandom, $urandom}), pptec_pkg::LEVEL_W'($urandom));
      end else begin
        send_word(CMD_UNKNOWN, pptec_pkg::TAG_W'($urandom),
                  pptec_pkg::TIME_W'({$urandom, $urandom}), pptec_pkg::LEVEL_W'($urandom));
        done_items = done_items - 1;
      end
      done_items = done_items + 1;
    end
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= pptec_pkg::CFG_ENABLED;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= pptec_pkg::CMD_PACKET;
    in_ch.packet_tag  <= '0;
    in_ch.time_ms     <= '0;
    in_ch.alarm_level <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: packet and alarm do nothing, flush has no session to close.
    send_word(pptec_pkg::CMD_PACKET, '1, '0, 2'd3);
    send_word(pptec_pkg::CMD_ALARM, pptec_pkg::TAG_W'($urandom), pptec_pkg::TIME_W'(100),
              2'd3);
    send_word(pptec_pkg::CMD_FLUSH, '0, '0, '0);

    apply_settings(1'b1, 2'd1, pptec_pkg::ROLL_W'(5000), pptec_pkg::ROLL_W'(5000));
    send_word(pptec_pkg::CMD_PACKET, '0, pptec_pkg::TIME_W'(0), 2'd0);
    send_word(pptec_pkg::CMD_PACKET, '1, pptec_pkg::TIME_W'(1000), 2'd0);
    send_word(pptec_pkg::CMD_PACKET, pptec_pkg::TAG_W'($urandom), pptec_pkg::TIME_W'(4000),
              2'd0);
    send_word(pptec_pkg::CMD_ALARM, '0, pptec_pkg::TIME_W'(4000), 2'd0);
    send_word(pptec_pkg::CMD_ALARM, '0, pptec_pkg::TIME_W'(6000), 2'd2);
    send_word(pptec_pkg::CMD_ALARM, '0, pptec_pkg::TIME_W'(8000), 2'd3);
    send_word(pptec_pkg::CMD_PACKET, pptec_pkg::TAG_W'($urandom), pptec_pkg::TIME_W'(9000),
              2'd0);
    send_word(pptec_pkg::CMD_PACKET, pptec_pkg::TAG_W'($urandom), pptec_pkg::TIME_W'(2000),
              2'd0);
    send_word(pptec_pkg::CMD_PACKET, pptec_pkg::TAG_W'($urandom), pptec_pkg::TIME_W'(13000),
              2'd0);
    send_word(pptec_pkg::CMD_FLUSH, '0, '0, '0);
    send_word(pptec_pkg::CMD_ALARM, '0, pptec_pkg::TIME_W'(13500), 2'd1);
    send_word(CMD_UNKNOWN, '1, pptec_pkg::TIME_MAX, 2'd3);
    send_word(pptec_pkg::CMD_FLUSH, '1, pptec_pkg::TIME_MAX, 2'd3);
    // Alarm at the top of the time range: the stop time saturates.
    send_word(pptec_pkg::CMD_ALARM, '0, pptec_pkg::TIME_MAX, 2'd3);
    send_word(pptec_pkg::CMD_PACKET, pptec_pkg::TAG_W'($urandom), pptec_pkg::TIME_MAX, 2'd0);
    send_word(pptec_pkg::CMD_ALARM, '0, pptec_pkg::TIME_W'(20000), 2'd1);

    // The session stays open across the packet ignored while disabled; flush must still close it.
    apply_settings(1'b0, 2'd1, pptec_pkg::ROLL_W'(5000), pptec_pkg::ROLL_W'(5000));
    send_word(pptec_pkg::CMD_PACKET, pptec_pkg::TAG_W'($urandom), pptec_pkg::TIME_W'(21000),
              2'd0);
    send_word(pptec_pkg::CMD_FLUSH, '0, '0, '0);

    apply_settings(1'b1, 2'd0, pptec_pkg::ROLL_W'(0), pptec_pkg::ROLL_W'(0));
    run_random(PHASE_ITEMS, pptec_pkg::TIME_W'(30000));

    apply_settings(1'b1, 2'd3, pptec_pkg::ROLL_W'(600000), pptec_pkg::ROLL_W'(600000));
    idle_pct  = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS, pptec_pkg::TIME_MAX - pptec_pkg::TIME_W'(900000));
    idle_pct  = 22;
    stall_pct = 22;

    apply_settings(1'b1, 2'd2, pptec_pkg::ROLL_W'($urandom_range(600000)),
                   pptec_pkg::ROLL_W'($urandom_range(600000)));
    run_random(PHASE_ITEMS, pptec_pkg::TIME_W'({$urandom, $urandom}));

    apply_settings(1'b1, 2'd1, pptec_pkg::ROLL_W'($urandom_range(20000)),
                   pptec_pkg::ROLL_W'($urandom_range(20000)));
    run_random(PHASE_ITEMS, pptec_pkg::TIME_W'(0));

    hold_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
design/pptec_pkg.sv
design/pptec_if.sv
design/pptec_ring_mem.sv
design/pre_post_trigger_event_capture.sv
sim/tb_pre_post_trigger_event_capture.sv
